// File: hdl/irb_pkg.sv
// Package for the bilinear image rotation block.
// Holds the configuration record, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none
package irb_pkg;
	localparam int Q_BITS = 14;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COS_Q14      = 3'd2,
		REG_SIN_Q14      = 3'd3,
		REG_GRAY_MODE    = 3'd4
	} cfg_reg_t;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic [8:0]         image_width;
		logic [8:0]         image_height;
		logic signed [15:0] cos_q14;
		logic signed [15:0] sin_q14;
		logic               gray_mode;
	} cfg_t;
endpackage
`default_nettype wire

// File: hdl/image_rotate_bilinear.sv
// Bilinear image rotation: top level with configuration registers,
// front end, queue and back end. Depends on irb_pkg, irb_front, irb_fifo, irb_back.
// Path: a query passes the front stages, the queue, the back-end stages and the output
// register; done and the result are registered together.
// Throughput: one item per cycle, writes and queries mixed in any order.
// Writes take no result; the receiver cannot stall, so busy stays low in use.
// Reset clears the registers to 256x256, identity rotation, color mode.
`default_nettype none
module image_rotate_bilinear #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [7:0]  pos_x,
	input  wire logic [7:0]  pos_y,
	input  wire logic [7:0]  pixel_c0,
	input  wire logic [7:0]  pixel_c1,
	input  wire logic [7:0]  pixel_c2,
	output logic             done,
	output logic [7:0]       out_c0,
	output logic [7:0]       out_c1,
	output logic [7:0]       out_c2,
	output logic             inside_res,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import irb_pkg::*;

	localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int EW = 2 + XW + YW + 2 * FRAC_BITS + 24;
	localparam int QDEPTH = 4;
	// Items in the two front stages may still land in the queue.
	localparam int FRONT_STAGES = 2;

	cfg_t cfg_q;
	logic take, push, empty, pop;
	logic [EW-1:0] push_data, pop_data;
	logic [$clog2(QDEPTH+1)-1:0] count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 9'd256;
			cfg_q.image_height <= 9'd256;
			cfg_q.cos_q14      <= 16'sd16384;
			cfg_q.sin_q14      <= 16'sd0;
			cfg_q.gray_mode    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[8:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[8:0];
				REG_COS_Q14:      cfg_q.cos_q14      <= $signed(cfg_data);
				REG_SIN_Q14:      cfg_q.sin_q14      <= $signed(cfg_data);
				REG_GRAY_MODE:    cfg_q.gray_mode    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The back end drains one entry per cycle, so the queue only holds
	// entries briefly; busy guards the room still needed for items in flight.
	assign busy = (32'(count) + FRONT_STAGES >= QDEPTH);
	assign take = start && !busy;

	irb_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS),
		.XW(XW), .YW(YW), .EW(EW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .take(take), .func(func),
		.pos_x(pos_x), .pos_y(pos_y), .pixel({pixel_c2, pixel_c1, pixel_c0}),
		.push(push), .push_data(push_data)
	);

	irb_fifo #(.WIDTH(EW), .DEPTH(QDEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .pop_data(pop_data), .empty(empty), .count(count)
	);

	irb_back #(.FRAC_BITS(FRAC_BITS), .XW(XW), .YW(YW), .EW(EW)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .has_item(!empty), .item(pop_data),
		.pop(pop), .done(done), .out_c0(out_c0), .out_c1(out_c1), .out_c2(out_c2),
		.inside_res(inside_res)
	);
endmodule
`default_nettype wire

// File: hdl/irb_fifo.sv
// Short queue between the coordinate front end and the sampling back end.
// Generic payload width; no package dependencies.
`default_nettype none
module irb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign count    = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == ($clog2(DEPTH+1))'(DEPTH)))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ($clog2(DEPTH+1))'(DEPTH))
		else $error("queue count out of range");
endmodule
`default_nettype wire

// File: hdl/irb_front.sv
// Front end: takes items, maps query positions through the rotation and
// classifies them as inside or outside. Depends on irb_pkg.
`default_nettype none
module irb_front #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8,
	parameter int XW = 8,
	parameter int YW = 8,
	parameter int EW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire irb_pkg::cfg_t cfg,
	input  wire logic          take,
	input  wire logic          func,
	input  wire logic [7:0]    pos_x,
	input  wire logic [7:0]    pos_y,
	input  wire logic [23:0]   pixel,
	output logic               push,
	output logic [EW-1:0]      push_data
);
	import irb_pkg::*;

	logic [8:0] w_eff, h_eff;
	logic [7:0] cx, cy;

	logic              v_s1, func_s1, out_s1, wr_ok_s1;
	logic [7:0]        x_s1, y_s1, cx_s1, cy_s1;
	logic signed [9:0] dx_s1, dy_s1;
	logic [23:0]       pix_s1;

	logic               v_s2, func_s2, out_s2, wr_ok_s2;
	logic [7:0]         x_s2, y_s2, cx_s2, cy_s2;
	logic signed [25:0] cdx_s2, sdy_s2, cdy_s2, sdx_s2;
	logic [23:0]        pix_s2;

	logic signed [29:0] rx, ry, limx, limy;
	logic               in_area;
	logic [XW-1:0]      px;
	logic [YW-1:0]      py;
	logic [FRAC_BITS-1:0] fx, fy;

	always_comb begin
		w_eff = (32'(cfg.image_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg.image_width;
		h_eff = (32'(cfg.image_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg.image_height;
		cx = w_eff[8:1];
		cy = h_eff[8:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s1  <= func;
		x_s1     <= pos_x;
		y_s1     <= pos_y;
		cx_s1    <= cx;
		cy_s1    <= cy;
		pix_s1   <= pixel;
		out_s1   <= ({1'b0, pos_x} >= w_eff) || ({1'b0, pos_y} >= h_eff);
		wr_ok_s1 <= (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
		dx_s1    <= $signed({2'b0, pos_x}) - $signed({2'b0, cx});
		dy_s1    <= $signed({2'b0, pos_y}) - $signed({2'b0, cy});

		func_s2  <= func_s1;
		x_s2     <= x_s1;
		y_s2     <= y_s1;
		cx_s2    <= cx_s1;
		cy_s2    <= cy_s1;
		pix_s2   <= pix_s1;
		out_s2   <= out_s1;
		wr_ok_s2 <= wr_ok_s1;
		cdx_s2   <= cfg.cos_q14 * dx_s1;
		sdy_s2   <= cfg.sin_q14 * dy_s1;
		cdy_s2   <= cfg.cos_q14 * dy_s1;
		sdx_s2   <= cfg.sin_q14 * dx_s1;
	end

	// Source position in Q14, then the range test against the interpolation area.
	always_comb begin
		rx   = 30'(cdx_s2) + 30'(sdy_s2) + $signed({8'b0, cx_s2, 14'b0});
		ry   = 30'(cdy_s2) - 30'(sdx_s2) + $signed({8'b0, cy_s2, 14'b0});
		limx = $signed({7'b0, 9'(w_eff - 9'd1), 14'b0});
		limy = $signed({7'b0, 9'(h_eff - 9'd1), 14'b0});
		in_area = !out_s2 && (rx >= 0) && (rx < limx) && (ry >= 0) && (ry < limy)
			&& (w_eff >= 9'd2) && (h_eff >= 9'd2);
		fx = rx[Q_BITS-1 -: FRAC_BITS];
		fy = ry[Q_BITS-1 -: FRAC_BITS];
		if (func_s2 == FUNC_QUERY) begin
			px = rx[Q_BITS+XW-1:Q_BITS];
			py = ry[Q_BITS+YW-1:Q_BITS];
		end else begin
			px = XW'(x_s2);
			py = YW'(y_s2);
		end
	end

	assign push = v_s2;
	assign push_data = {func_s2, (func_s2 == FUNC_QUERY) ? in_area : wr_ok_s2,
		px, py, fx, fy, pix_s2};
endmodule
`default_nettype wire

// File: hdl/irb_back.sv
// Back end: frame store in four banks by row and column parity, neighbor
// fetch, bilinear blend, rounding and saturation. Depends on irb_pkg.
`default_nettype none
module irb_back #(
	parameter int FRAC_BITS = 8,
	parameter int XW = 8,
	parameter int YW = 8,
	parameter int EW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire irb_pkg::cfg_t cfg,
	input  wire logic          has_item,
	input  wire logic [EW-1:0] item,
	output logic               pop,
	output logic               done,
	output logic [7:0]         out_c0,
	output logic [7:0]         out_c1,
	output logic [7:0]         out_c2,
	output logic               inside_res
);
	import irb_pkg::*;

	localparam int AXW = (XW > 1) ? XW - 1 : 1;
	localparam int AYW = (YW > 1) ? YW - 1 : 1;
	localparam int AW  = AXW + AYW;
	localparam int WW  = 2 * FRAC_BITS + 2;
	localparam int ACW = 2 * FRAC_BITS + 11;

	logic                 e_query, e_active;
	logic [XW-1:0]        e_px;
	logic [YW-1:0]        e_py;
	logic [FRAC_BITS-1:0] e_fx, e_fy;
	logic [23:0]          e_pix;

	logic [AXW-1:0] xh0, xh1;
	logic [AYW-1:0] yh0, yh1;
	logic [AW-1:0]  raddr [4];
	logic [AW-1:0]  waddr;
	logic [1:0]     wbank;
	logic           wen;
	logic [23:0]    rd_s1 [4];

	logic                 v_s1, q_s1, in_s1, bx_s1, by_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1;

	logic                 v_s2, q_s2, in_s2;
	logic [WW-1:0]        wt_s2 [4];
	logic [23:0]          p_s2 [4];

	logic [FRAC_BITS:0]   ofx, ofy;
	logic [23:0]          nb [4];
	logic [ACW-1:0]       acc [3];
	logic [7:0]           sat [3];

	assign {e_query, e_active, e_px, e_py, e_fx, e_fy, e_pix} = item;
	assign pop = has_item;

	// Even banks take the right-hand or lower neighbor when the position is odd.
	always_comb begin
		xh1 = AXW'(e_px >> 1);
		yh1 = AYW'(e_py >> 1);
		xh0 = AXW'(({1'b0, e_px} + 1'b1) >> 1);
		yh0 = AYW'(({1'b0, e_py} + 1'b1) >> 1);
		raddr[0] = {yh0, xh0};
		raddr[1] = {yh0, xh1};
		raddr[2] = {yh1, xh0};
		raddr[3] = {yh1, xh1};
		waddr = {yh1, xh1};
		wbank = {e_py[0], e_px[0]};
		wen   = has_item && (e_query == FUNC_WRITE) && e_active;
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [23:0] mem [2**AW];
		always_ff @(posedge clk) begin
			if (wen && wbank == 2'(b))
				mem[waddr] <= e_pix;
			rd_s1[b] <= mem[raddr[b]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= has_item && (e_query == FUNC_QUERY);
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_comb begin
		ofx = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fx_s1};
		ofy = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fy_s1};
		nb[0] = rd_s1[{by_s1, bx_s1}];
		nb[1] = rd_s1[{by_s1, ~bx_s1}];
		nb[2] = rd_s1[{~by_s1, bx_s1}];
		nb[3] = rd_s1[{~by_s1, ~bx_s1}];
	end

	always_ff @(posedge clk) begin
		q_s1  <= e_query;
		in_s1 <= e_active;
		bx_s1 <= e_px[0];
		by_s1 <= e_py[0];
		fx_s1 <= e_fx;
		fy_s1 <= e_fy;

		q_s2  <= q_s1;
		in_s2 <= in_s1;
		wt_s2[0] <= WW'(ofx * ofy);
		wt_s2[1] <= WW'({1'b0, fx_s1} * ofy);
		wt_s2[2] <= WW'(ofx * {1'b0, fy_s1});
		wt_s2[3] <= WW'({1'b0, fx_s1} * {1'b0, fy_s1});
		for (int k = 0; k < 4; k++)
			p_s2[k] <= nb[k];
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = ACW'(1 << (2 * FRAC_BITS - 1));
			for (int k = 0; k < 4; k++)
				acc[ch] = acc[ch] + ACW'(wt_s2[k] * p_s2[k][8*ch +: 8]);
			acc[ch] = acc[ch] >> (2 * FRAC_BITS);
			sat[ch] = (acc[ch] > ACW'(255)) ? 8'd255 : acc[ch][7:0];
		end
	end

	always_ff @(posedge clk) begin
		inside_res <= in_s2;
		out_c0 <= in_s2 ? sat[0] : 8'd0;
		out_c1 <= (in_s2 && !cfg.gray_mode) ? sat[1] : 8'd0;
		out_c2 <= (in_s2 && !cfg.gray_mode) ? sat[2] : 8'd0;
	end

	a_query_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> q_s2)
		else $error("non-query reached the blend stage");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s2))
		else $error("strobe without a blended item");
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !inside_res |-> out_c0 == 8'd0 && out_c1 == 8'd0 && out_c2 == 8'd0)
		else $error("outside query with a nonzero pixel");
endmodule
`default_nettype wire
